FILE: hw/rtl/montgomery_modular_alu_core_macros.svh
// Assertion helpers used by the asserting top-level core module.
`ifndef MONTGOMERY_MODULAR_ALU_CORE_MACROS_SVH
`define MONTGOMERY_MODULAR_ALU_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MMA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mma check failed");

// Next-cycle implication, checked outside reset.
`define MMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mma check failed");

`endif

FILE: hw/rtl/mma_pkg.sv
`default_nettype none
package mma_pkg;

  localparam int WORD_W = 32;
  localparam int MOD_W = 31;
  localparam int OP_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [OP_W-1:0] OP_TO_MONT   = 4'd0;
  localparam logic [OP_W-1:0] OP_FROM_MONT = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD       = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB       = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL       = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV       = 4'd5;
  localparam logic [OP_W-1:0] OP_NEG       = 4'd6;
  localparam logic [OP_W-1:0] OP_INC       = 4'd7;
  localparam logic [OP_W-1:0] OP_DEC       = 4'd8;
  localparam logic [OP_W-1:0] OP_CMP       = 4'd9;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_INVERSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MONT_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R_SQUARED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R_CUBED     = 3'd4;

  localparam logic [MOD_W-1:0]  RST_MODULUS     = 31'd998244353;
  localparam logic [WORD_W-1:0] RST_NEG_INVERSE = 32'd998244351;
  localparam logic [MOD_W-1:0]  RST_MONT_ONE    = 31'd301989884;
  localparam logic [MOD_W-1:0]  RST_R_SQUARED   = 31'd932051910;
  localparam logic [MOD_W-1:0]  RST_R_CUBED     = 31'd679058953;

  typedef enum logic [1:0] {
    KIND_ALU,
    KIND_MONT,
    KIND_DIV
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } cmd_t;

  typedef struct packed {
    logic [MOD_W-1:0]  modulus;
    logic [WORD_W-1:0] neg_inverse;
    logic [MOD_W-1:0]  mont_one;
    logic [MOD_W-1:0]  r_squared;
    logic [MOD_W-1:0]  r_cubed;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mma_front.sv
`default_nettype none
module mma_front import mma_pkg::*; (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [WORD_W-1:0] operand_a,
  input  wire logic [WORD_W-1:0] operand_b,
  input  wire logic              q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  kind_t kind;

  always_comb begin
    if (op inside {OP_TO_MONT, OP_FROM_MONT, OP_MUL}) begin
      kind = KIND_MONT;
    end else if (op == OP_DIV) begin
      kind = KIND_DIV;
    end else begin
      kind = KIND_ALU;
    end
  end

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;
  assign q_cmd = '{kind: kind, op: op, a: operand_a, b: operand_b};

endmodule
`default_nettype wire

FILE: hw/rtl/mma_queue.sv
`default_nettype none
module mma_queue import mma_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output cmd_t      head_cmd
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W:0]   count;
  logic [QPTR_W-1:0] tail;

  assign tail = head + count[QPTR_W-1:0];
  assign full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mma_back.sv
`default_nettype none
module mma_back import mma_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  cfg_t                   cfg,
  input  wire logic              q_valid,
  input  cmd_t                   q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [MOD_W-1:0]       result,
  output logic                   equal,
  output logic                   less,
  output logic                   error
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T,
    ST_Q,
    ST_P,
    ST_S,
    ST_F,
    ST_ECHK,
    ST_EDIV,
    ST_EUPD,
    ST_DONE
  } state_t;

  localparam int ACC_W = 36;

  state_t                   state;
  logic [WORD_W-1:0]        opa, opb, save_a, qv, v;
  logic [2*WORD_W-1:0]      t, p, prod, sum;
  logic                     do_sub, chain;
  logic [WORD_W-1:0]        mx, my;
  logic [MOD_W-1:0]         res_r;
  logic                     eq_r, lt_r, err_r;
  logic [WORD_W-1:0]        ey, en, dsh;
  logic [WORD_W:0]          rem, remsh, rem_next;
  logic signed [ACC_W-1:0]  ew, ex, wz, wfix;
  logic [4:0]               cnt;
  logic                     ge;
  logic [WORD_W-1:0]        m32, alu_res, s_add, s_sub, vfix;
  logic                     alu_eq, alu_lt;
  logic                     out_free;

  assign m32 = {1'b0, cfg.modulus};
  assign out_free = !out_valid || !out_stall;
  assign q_pop = (state == ST_IDLE) && q_valid;

  // One shared 32x32 multiplier, registered after every use.
  always_comb begin
    case (state)
      ST_Q:    begin mx = t[WORD_W-1:0]; my = cfg.neg_inverse; end
      ST_P:    begin mx = qv; my = m32; end
      default: begin mx = opa; my = opb; end
    endcase
  end
  assign prod = mx * my;
  assign sum = t + p;
  assign vfix = (do_sub && (v >= m32)) ? v - m32 : v;

  // Short ops, done straight from the queue head.
  always_comb begin
    alu_res = '0;
    alu_eq = 1'b0;
    alu_lt = 1'b0;
    s_add = '0;
    s_sub = '0;
    case (q_cmd.op)
      OP_ADD: begin
        s_add = q_cmd.a + q_cmd.b;
        alu_res = (s_add >= m32) ? s_add - m32 : s_add;
      end
      OP_SUB: begin
        s_sub = q_cmd.a - q_cmd.b;
        alu_res = (s_sub >= m32) ? s_sub + m32 : s_sub;
      end
      OP_INC: begin
        s_add = q_cmd.a + {1'b0, cfg.mont_one};
        alu_res = (s_add >= m32) ? s_add - m32 : s_add;
      end
      OP_DEC: begin
        s_sub = q_cmd.a - {1'b0, cfg.mont_one};
        alu_res = (s_sub >= m32) ? s_sub + m32 : s_sub;
      end
      OP_NEG: begin
        alu_res = (q_cmd.a != '0) ? m32 - q_cmd.a : '0;
      end
      OP_CMP: begin
        alu_eq = (q_cmd.a == q_cmd.b);
        alu_lt = (q_cmd.a < q_cmd.b);
      end
      default: begin
        alu_res = '0;
      end
    endcase
  end

  // One restoring-division step of Euclid; the quotient bits also build w*z.
  assign remsh = {rem[WORD_W-1:0], dsh[WORD_W-1]};
  assign ge = (remsh >= {1'b0, en});
  assign rem_next = ge ? remsh - {1'b0, en} : remsh;
  assign wfix = (ew < 0) ? ew + signed'(ACC_W'(cfg.modulus)) : ew;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            eq_r <= 1'b0;
            lt_r <= 1'b0;
            err_r <= 1'b0;
            res_r <= '0;
            chain <= 1'b0;
            do_sub <= 1'b1;
            save_a <= q_cmd.a;
            case (q_cmd.kind)
              KIND_MONT: begin
                if (q_cmd.op == OP_FROM_MONT) begin
                  t <= {{WORD_W{1'b0}}, q_cmd.a};
                  do_sub <= 1'b0;
                  state <= ST_Q;
                end else if (q_cmd.op == OP_TO_MONT) begin
                  opa <= {1'b0, cfg.r_squared};
                  opb <= q_cmd.a;
                  state <= ST_T;
                end else begin
                  opa <= q_cmd.a;
                  opb <= q_cmd.b;
                  state <= ST_T;
                end
              end
              KIND_DIV: begin
                ey <= m32;
                en <= q_cmd.b;
                ew <= ACC_W'(1);
                ex <= '0;
                state <= ST_ECHK;
              end
              default: begin
                res_r <= alu_res[MOD_W-1:0];
                eq_r <= alu_eq;
                lt_r <= alu_lt;
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_T: begin
          t <= prod;
          state <= ST_Q;
        end
        ST_Q: begin
          qv <= prod[WORD_W-1:0];
          state <= ST_P;
        end
        ST_P: begin
          p <= prod;
          state <= ST_S;
        end
        ST_S: begin
          v <= sum[2*WORD_W-1:WORD_W];
          state <= ST_F;
        end
        ST_F: begin
          if (chain) begin
            // The rescaled inverse is ready: now multiply the dividend by it.
            opa <= save_a;
            opb <= v;
            chain <= 1'b0;
            do_sub <= 1'b1;
            state <= ST_T;
          end else begin
            res_r <= vfix[MOD_W-1:0];
            state <= ST_DONE;
          end
        end
        ST_ECHK: begin
          if (en == WORD_W'(1)) begin
            opa <= {1'b0, cfg.r_cubed};
            opb <= wfix[WORD_W-1:0];
            chain <= 1'b1;
            do_sub <= 1'b0;
            state <= ST_T;
          end else if (en == '0) begin
            err_r <= 1'b1;
            state <= ST_DONE;
          end else begin
            rem <= '0;
            dsh <= ey;
            wz <= '0;
            cnt <= 5'd31;
            state <= ST_EDIV;
          end
        end
        ST_EDIV: begin
          rem <= rem_next;
          dsh <= dsh << 1;
          wz <= (wz <<< 1) + (ge ? ew : ACC_W'(0));
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_EUPD;
          end
        end
        ST_EUPD: begin
          ey <= en;
          en <= rem[WORD_W-1:0];
          ew <= ex - wz;
          ex <= ew;
          state <= ST_ECHK;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            result <= res_r;
            equal <= eq_r;
            less <= lt_r;
            error <= err_r;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/montgomery_modular_alu_core.sv
// Modular arithmetic unit on Montgomery-form values over an odd modulus.
// Input channel: in_valid/in_stall with op, operand_a, operand_b; an item is
// taken when in_valid is high and in_stall low. Output channel: out_valid and
// out_stall with result, equal, less and error, one result per item, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high; the user must write registers only while the unit is idle, which the block itself does not enforce.
// A two-entry queue sits between the input side and the execution engine, so
// items are taken while earlier ones are still being worked on.
// Add, sub, neg, inc, dec and compare are done straight from the queue head;
// from_mont takes two dependent products and to_mont and mul take three,
// all on one shared 32x32 multiplier. Divide runs extended Euclid with a
// one-bit-per-cycle divider, plus two chained reductions.
// Items are handled one at a time in the engine.
// Reset restores the default modulus and constants and empties the queue.
// While out_stall is high a finished result waits in the output register and
// the engine holds its next result; the queue keeps filling until full.
`default_nettype none
module montgomery_modular_alu_core import mma_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      op,
  input  wire logic [WORD_W-1:0]    operand_a,
  input  wire logic [WORD_W-1:0]    operand_b,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [MOD_W-1:0]          result,
  output logic                      equal,
  output logic                      less,
  output logic                      error,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

`include "montgomery_modular_alu_core_macros.svh"

  cfg_t cfg;
  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus <= RST_MODULUS;
      cfg.neg_inverse <= RST_NEG_INVERSE;
      cfg.mont_one <= RST_MONT_ONE;
      cfg.r_squared <= RST_R_SQUARED;
      cfg.r_cubed <= RST_R_CUBED;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:     cfg.modulus <= cfg_data[MOD_W-1:0];
        REG_NEG_INVERSE: cfg.neg_inverse <= cfg_data;
        REG_MONT_ONE:    cfg.mont_one <= cfg_data[MOD_W-1:0];
        REG_R_SQUARED:   cfg.r_squared <= cfg_data[MOD_W-1:0];
        REG_R_CUBED:     cfg.r_cubed <= cfg_data[MOD_W-1:0];
        default:         cfg <= cfg;
      endcase
    end
  end

  mma_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  mma_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_cmd  (head_cmd)
  );

  mma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .equal     (equal),
    .less      (less),
    .error     (error)
  );

  // A failed division reports nothing but the error flag.
  `MMA_ASSERT_IMPL(a_err_clean, out_valid && error, result == '0 && !equal && !less)
  // Compare flags come only from compare, which has a zero result.
  `MMA_ASSERT_IMPL(a_cmp_clean, out_valid && (equal || less), result == '0 && !error)
  // Equal and less never hold together.
  `MMA_ASSERT_IMPL(a_eq_lt, out_valid && equal, !less)

endmodule
`default_nettype wire
